### sv/hsv_pkg.sv
package hsv_pkg;

	localparam int CHANNEL_BITS      = 8;
	localparam int HUE_FRACTION_BITS = 6;
	localparam int HUE_BITS          = 15;

	localparam int CH_MAX     = (1 << CHANNEL_BITS) - 1;
	localparam int HUE_SIXTY  = 60 << HUE_FRACTION_BITS;
	localparam int HUE_FULL   = 360 << HUE_FRACTION_BITS;
	localparam int HUE_CALC_BITS = $clog2(HUE_FULL + 1);
	localparam int HUE_Q_BITS = $clog2(HUE_SIXTY + 1);

	// one quotient width covers both divisions
	localparam int Q_BITS   = (CHANNEL_BITS > HUE_Q_BITS) ? CHANNEL_BITS : HUE_Q_BITS;
	localparam int DVD_BITS = CHANNEL_BITS + Q_BITS;

	typedef enum logic [1:0] {
		SECTOR_RED,
		SECTOR_GREEN,
		SECTOR_BLUE
	} sector_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] brightness;
		sector_t                 sector;
		logic                    neg;
		logic                    defined;
	} side_t;

endpackage

### sv/hsv_front.sv
module hsv_front
	import hsv_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [CHANNEL_BITS-1:0] red,
	input  logic [CHANNEL_BITS-1:0] green,
	input  logic [CHANNEL_BITS-1:0] blue,
	output logic                    valid_s2,
	output logic [DVD_BITS-1:0]     sat_dvd_s2,
	output logic [CHANNEL_BITS-1:0] sat_dvs_s2,
	output logic [DVD_BITS-1:0]     hue_dvd_s2,
	output logic [CHANNEL_BITS-1:0] hue_dvs_s2,
	output side_t                   side_s2
);

	logic [CHANNEL_BITS-1:0] mx, mn, delta;
	logic [CHANNEL_BITS:0]   num;
	logic [CHANNEL_BITS-1:0] num_abs;
	sector_t                 sector;

	logic                    valid_s1;
	logic [CHANNEL_BITS-1:0] mx_s1, delta_s1, num_abs_s1;
	sector_t                 sector_s1;
	logic                    neg_s1;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (green < mn) mn = green;
		if (blue > mx) mx = blue;
		if (blue < mn) mn = blue;
		delta = mx - mn;
		// red wins ties, then green
		if (red == mx) begin
			sector = SECTOR_RED;
			num    = {1'b0, green} - {1'b0, blue};
		end else if (green == mx) begin
			sector = SECTOR_GREEN;
			num    = {1'b0, blue} - {1'b0, red};
		end else begin
			sector = SECTOR_BLUE;
			num    = {1'b0, red} - {1'b0, green};
		end
		num_abs = num[CHANNEL_BITS] ? CHANNEL_BITS'(-num) : num[CHANNEL_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1      <= mx;
		delta_s1   <= delta;
		num_abs_s1 <= num_abs;
		sector_s1  <= sector;
		neg_s1     <= num[CHANNEL_BITS];

		sat_dvd_s2 <= DVD_BITS'(delta_s1) * DVD_BITS'(CH_MAX);
		sat_dvs_s2 <= mx_s1;
		hue_dvd_s2 <= DVD_BITS'(num_abs_s1) * DVD_BITS'(HUE_SIXTY);
		hue_dvs_s2 <= delta_s1;
		side_s2.brightness <= mx_s1;
		side_s2.sector     <= sector_s1;
		side_s2.neg        <= neg_s1;
		side_s2.defined    <= (delta_s1 != '0);
	end

endmodule

### sv/hsv_div_pipe.sv
module hsv_div_pipe
	import hsv_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [DVD_BITS-1:0]     sat_dvd,
	input  logic [CHANNEL_BITS-1:0] sat_dvs,
	input  logic [DVD_BITS-1:0]     hue_dvd,
	input  logic [CHANNEL_BITS-1:0] hue_dvs,
	input  side_t                   side_in,
	output logic                    out_valid,
	output logic [Q_BITS-1:0]       sat_quo,
	output logic [Q_BITS-1:0]       hue_quo,
	output side_t                   side_out
);

	// restoring division, one quotient bit per stage, msb first
	logic                    valid_s   [Q_BITS+1];
	logic [DVD_BITS-1:0]     sat_rem_s [Q_BITS+1];
	logic [DVD_BITS-1:0]     hue_rem_s [Q_BITS+1];
	logic [CHANNEL_BITS-1:0] sat_dvs_s [Q_BITS+1];
	logic [CHANNEL_BITS-1:0] hue_dvs_s [Q_BITS+1];
	logic [Q_BITS-1:0]       sat_quo_s [Q_BITS+1];
	logic [Q_BITS-1:0]       hue_quo_s [Q_BITS+1];
	side_t                   side_s    [Q_BITS+1];

	assign valid_s[0]   = in_valid;
	assign sat_rem_s[0] = sat_dvd;
	assign hue_rem_s[0] = hue_dvd;
	assign sat_dvs_s[0] = sat_dvs;
	assign hue_dvs_s[0] = hue_dvs;
	assign sat_quo_s[0] = '0;
	assign hue_quo_s[0] = '0;
	assign side_s[0]    = side_in;

	for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
		localparam int BIT = Q_BITS - 1 - k;
		logic [DVD_BITS-1:0] sat_step, hue_step;
		logic                sat_fit, hue_fit;

		always_comb begin
			sat_step = DVD_BITS'(sat_dvs_s[k]) << BIT;
			hue_step = DVD_BITS'(hue_dvs_s[k]) << BIT;
			sat_fit  = sat_rem_s[k] >= sat_step;
			hue_fit  = hue_rem_s[k] >= hue_step;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			sat_rem_s[k+1] <= sat_fit ? sat_rem_s[k] - sat_step : sat_rem_s[k];
			hue_rem_s[k+1] <= hue_fit ? hue_rem_s[k] - hue_step : hue_rem_s[k];
			sat_dvs_s[k+1] <= sat_dvs_s[k];
			hue_dvs_s[k+1] <= hue_dvs_s[k];
			sat_quo_s[k+1] <= sat_quo_s[k] | (Q_BITS'(sat_fit) << BIT);
			hue_quo_s[k+1] <= hue_quo_s[k] | (Q_BITS'(hue_fit) << BIT);
			side_s[k+1]    <= side_s[k];
		end
	end

	assign out_valid = valid_s[Q_BITS];
	assign sat_quo   = sat_quo_s[Q_BITS];
	assign hue_quo   = hue_quo_s[Q_BITS];
	assign side_out  = side_s[Q_BITS];

`ifndef SYNTHESIS
	// the channel difference never exceeds delta, so the hue quotient stays within one sector
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && side_out.defined |-> hue_quo <= Q_BITS'(HUE_SIXTY))
		else $error("hue quotient above one sector");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && side_out.defined |-> sat_quo <= Q_BITS'(CH_MAX))
		else $error("saturation quotient out of range");
`endif

endmodule

### sv/hsv_back.sv
module hsv_back
	import hsv_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [Q_BITS-1:0]       sat_quo,
	input  logic [Q_BITS-1:0]       hue_quo,
	input  side_t                   side_in,
	output logic                    done,
	output logic [HUE_BITS-1:0]     hue,
	output logic [CHANNEL_BITS-1:0] saturation,
	output logic [CHANNEL_BITS-1:0] brightness,
	output logic                    hue_defined
);

	logic [HUE_CALC_BITS-1:0] base, frac, hue_calc;

	always_comb begin
		frac = HUE_CALC_BITS'(hue_quo);
		case (side_in.sector)
			SECTOR_RED:   base = '0;
			SECTOR_GREEN: base = HUE_CALC_BITS'(2 * HUE_SIXTY);
			SECTOR_BLUE:  base = HUE_CALC_BITS'(4 * HUE_SIXTY);
			default:      base = '0;
		endcase
		if (!side_in.defined) begin
			hue_calc = '0;
		end else if (!side_in.neg) begin
			hue_calc = base + frac;
		end else if (side_in.sector == SECTOR_RED && frac != '0) begin
			// negative red-sector hue wraps round the circle
			hue_calc = HUE_CALC_BITS'(HUE_FULL) - frac;
		end else begin
			hue_calc = base - frac;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		hue         <= HUE_BITS'(hue_calc);
		saturation  <= side_in.defined ? sat_quo[CHANNEL_BITS-1:0] : '0;
		brightness  <= side_in.brightness;
		hue_defined <= side_in.defined;
	end

endmodule

### sv/rgb_to_hsv_converter.sv
// Pixel-stream RGB to HSV converter. A pixel is taken on every clock edge where start is
// high; busy is always low, so a new pixel may be offered every cycle. Each pixel comes
// out in order, as a one-cycle done strobe with hue, saturation, brightness and
// hue_defined; the receiver must take it then, as nothing is held. The pipeline is
// made of the two restoring dividers, one quotient bit per stage, plus a min/max
// stage, a scaling stage and an output stage. Hue is in 1/64 degree units; grey
// pixels give hue 0 and hue_defined low.
module rgb_to_hsv_converter
	import hsv_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [CHANNEL_BITS-1:0] red,
	input  logic [CHANNEL_BITS-1:0] green,
	input  logic [CHANNEL_BITS-1:0] blue,
	output logic                    done,
	output logic [HUE_BITS-1:0]     hue,
	output logic [CHANNEL_BITS-1:0] saturation,
	output logic [CHANNEL_BITS-1:0] brightness,
	output logic                    hue_defined
);

	logic                    accept;
	logic                    valid_s2;
	logic [DVD_BITS-1:0]     sat_dvd_s2, hue_dvd_s2;
	logic [CHANNEL_BITS-1:0] sat_dvs_s2, hue_dvs_s2;
	side_t                   side_s2;
	logic                    div_valid;
	logic [Q_BITS-1:0]       sat_quo, hue_quo;
	side_t                   div_side;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	hsv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.valid_s2   (valid_s2),
		.sat_dvd_s2 (sat_dvd_s2),
		.sat_dvs_s2 (sat_dvs_s2),
		.hue_dvd_s2 (hue_dvd_s2),
		.hue_dvs_s2 (hue_dvs_s2),
		.side_s2    (side_s2)
	);

	hsv_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.sat_dvd   (sat_dvd_s2),
		.sat_dvs   (sat_dvs_s2),
		.hue_dvd   (hue_dvd_s2),
		.hue_dvs   (hue_dvs_s2),
		.side_in   (side_s2),
		.out_valid (div_valid),
		.sat_quo   (sat_quo),
		.hue_quo   (hue_quo),
		.side_out  (div_side)
	);

	hsv_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (div_valid),
		.sat_quo     (sat_quo),
		.hue_quo     (hue_quo),
		.side_in     (div_side),
		.done        (done),
		.hue         (hue),
		.saturation  (saturation),
		.brightness  (brightness),
		.hue_defined (hue_defined)
	);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		done && hue_defined |-> saturation != '0)
		else $error("coloured pixel with zero saturation");
	assert property (@(posedge clk) disable iff (!arst_n)
		done && !hue_defined |-> hue == '0 && saturation == '0)
		else $error("grey pixel with hue or saturation");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> HUE_CALC_BITS'(hue) < HUE_CALC_BITS'(HUE_FULL))
		else $error("hue beyond full circle");
`endif

endmodule

### sim/testbench.sv
module testbench;
	import hsv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_PIXELS = 1250;
	localparam int PIPE_CYCLES   = 20;
	localparam int CYCLE_LIMIT   = 250000;

	typedef struct {
		logic [HUE_BITS-1:0]     hue;
		logic [CHANNEL_BITS-1:0] saturation;
		logic [CHANNEL_BITS-1:0] brightness;
		logic                    hue_defined;
	} hsv_t;

	class hsv_scoreboard;
		hsv_t expected_q[$];
		int   errors;
		int   checked;
		int   greys;
		int   wraps;

		// work out the HSV value of an accepted pixel and queue it
		function void note_pixel(logic [CHANNEL_BITS-1:0] r8, logic [CHANNEL_BITS-1:0] g8,
				logic [CHANNEL_BITS-1:0] b8);
			int      r, g, b, mx, mn, delta, num, base, h;
			sector_t sec;
			hsv_t    e;
			r = int'(r8);
			g = int'(g8);
			b = int'(b8);
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (g < mn) mn = g;
			if (b > mx) mx = b;
			if (b < mn) mn = b;
			delta = mx - mn;
			e.hue = '0;
			e.saturation = '0;
			e.brightness = mx[CHANNEL_BITS-1:0];
			e.hue_defined = 1'b0;
			if (delta > 0) begin
				e.saturation = CHANNEL_BITS'((CH_MAX * delta) / mx);
				if (r == mx) sec = SECTOR_RED;
				else if (g == mx) sec = SECTOR_GREEN;
				else sec = SECTOR_BLUE;
				case (sec)
					SECTOR_RED: begin
						base = 0;
						num = g - b;
					end
					SECTOR_GREEN: begin
						base = 2;
						num = b - r;
					end
					default: begin
						base = 4;
						num = r - g;
					end
				endcase
				// signed int division truncates toward zero
				h = base * HUE_SIXTY + (num * HUE_SIXTY) / delta;
				if (h < 0) begin
					h += HUE_FULL;
					wraps++;
				end
				e.hue = h[HUE_BITS-1:0];
				e.hue_defined = 1'b1;
			end else begin
				greys++;
			end
			expected_q.push_back(e);
		endfunction

		function void check_result(hsv_t got);
			hsv_t e;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%t: result with no pixel pending: hue %0d sat %0d val %0d def %0b",
					$realtime, got.hue, got.saturation, got.brightness, got.hue_defined);
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (got.hue !== e.hue) begin
				errors++;
				$display("%t: hue mismatch: expected %0d, actual %0d",
					$realtime, e.hue, got.hue);
			end
			if (got.saturation !== e.saturation) begin
				errors++;
				$display("%t: saturation mismatch: expected %0d, actual %0d",
					$realtime, e.saturation, got.saturation);
			end
			if (got.brightness !== e.brightness) begin
				errors++;
				$display("%t: brightness mismatch: expected %0d, actual %0d",
					$realtime, e.brightness, got.brightness);
			end
			if (got.hue_defined !== e.hue_defined) begin
				errors++;
				$display("%t: hue_defined mismatch: expected %0b, actual %0b",
					$realtime, e.hue_defined, got.hue_defined);
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [CHANNEL_BITS-1:0] red = '0;
	logic [CHANNEL_BITS-1:0] green = '0;
	logic [CHANNEL_BITS-1:0] blue = '0;
	logic                    done;
	logic [HUE_BITS-1:0]     hue;
	logic [CHANNEL_BITS-1:0] saturation;
	logic [CHANNEL_BITS-1:0] brightness;
	logic                    hue_defined;

	hsv_scoreboard sb = new();
	int            cycle_count = 0;
	int            pixels_sent = 0;

	rgb_to_hsv_converter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.done       (done),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.hue_defined(hue_defined)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		hsv_t got;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.expected_q.size());
			$display("*** FAILED ***");
			$finish;
		end else if (arst_n) begin
			if (start && !busy)
				sb.note_pixel(red, green, blue);
			if (done) begin
				got.hue = hue;
				got.saturation = saturation;
				got.brightness = brightness;
				got.hue_defined = hue_defined;
				sb.check_result(got);
			end
		end
	end

	// hold the request until the converter takes it
	task automatic send_pixel(logic [CHANNEL_BITS-1:0] r, logic [CHANNEL_BITS-1:0] g,
			logic [CHANNEL_BITS-1:0] b);
		@(negedge clk);
		start <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		pixels_sent++;
	endtask

	// drop the request, with junk on the channels
	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
			red <= CHANNEL_BITS'($urandom);
			green <= CHANNEL_BITS'($urandom);
			blue <= CHANNEL_BITS'($urandom);
		end
	endtask

	task automatic drain_results();
		idle_cycles(1);
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	logic [3*CHANNEL_BITS-1:0] corner_pixels [23] = '{
		24'h000000, 24'hffffff, 24'h808080, 24'h010101,
		24'hff0000, 24'h00ff00, 24'h0000ff,
		24'hffff00, 24'h00ffff, 24'hff00ff,
		24'hff0001, 24'h010000, 24'hfffefe, 24'h010100,
		24'h000101, 24'h010001, 24'h000001,
		24'hc83264, 24'h64c832, 24'h3264c8, 24'h32c864,
		24'haa5500, 24'h55aaff
	};

	initial begin
		int kind, gap, p, burst_mode;
		logic [CHANNEL_BITS-1:0] r, g, b, v;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// black, grey, pure primaries, ties between channels, wrapped hue, one-step deltas
		foreach (corner_pixels[i])
			send_pixel(corner_pixels[i][23:16], corner_pixels[i][15:8], corner_pixels[i][7:0]);
		drain_results();

		burst_mode = 0;
		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			if (i % 50 == 0)
				burst_mode = $urandom_range(0, 2);
			if (i == RANDOM_PIXELS / 2)
				drain_results();

			kind = $urandom_range(0, 9);
			r = CHANNEL_BITS'($urandom);
			g = CHANNEL_BITS'($urandom);
			b = CHANNEL_BITS'($urandom);
			v = CHANNEL_BITS'($urandom);
			case (kind)
				0: begin
					r = v;
					g = v;
					b = v;
				end
				1: begin
					// two channels tie
					case ($urandom_range(0, 2))
						0: g = r;
						1: b = g;
						default: b = r;
					endcase
				end
				2: begin
					r = CHANNEL_BITS'($urandom_range(0, 3));
					g = CHANNEL_BITS'($urandom_range(0, 3));
					b = CHANNEL_BITS'($urandom_range(0, 3));
				end
				3: begin
					case ($urandom_range(0, 2))
						0: r = '1;
						1: g = '1;
						default: b = '1;
					endcase
				end
				default: ;
			endcase
			send_pixel(r, g, b);

			if (burst_mode != 0) begin
				p = $urandom_range(0, 99);
				if (p < 65) gap = 0;
				else if (p < 92) gap = $urandom_range(1, 3);
				else gap = $urandom_range(8, 40);
				if (gap > 0)
					idle_cycles(gap);
			end
		end

		idle_cycles(1);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (PIPE_CYCLES) @(posedge clk);

		$display("%0d pixels sent, %0d results checked, %0d mismatches",
			pixels_sent, sb.checked, sb.errors);
		$display("covered %0d grey or black pixels and %0d hues wrapped below zero",
			sb.greys, sb.wraps);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
